@@ hw/rtl/abba_baba_d_statistic_macros.svh @@
// Assertion helpers for the D statistic RTL.
`ifndef ABBA_BABA_D_STATISTIC_MACROS_SVH
`define ABBA_BABA_D_STATISTIC_MACROS_SVH

`ifndef SYNTHESIS
`define AB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define AB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define AB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define AB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/abba_pkg.sv @@
`timescale 1ns / 1ps
package abba_pkg;

   // Result field widths
   localparam int D_WIDTH        = 16;
   localparam int D_FRAC_BITS    = 14;
   localparam int OUT_COUNT_BITS = 32;

   // One integer bit plus the fraction bits of the quotient
   localparam int Q_STEPS   = D_FRAC_BITS + 1;
   localparam int STEP_BITS = $clog2(Q_STEPS);

   // Depth of the queue between counting and division
   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } back_state_type;

endpackage

@@ hw/rtl/abba_front.sv @@
`timescale 1ns / 1ps
module abba_front #(
   parameter int STATE_BITS = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  site_valid,
   input  logic [STATE_BITS-1:0] state_p1,
   input  logic [STATE_BITS-1:0] state_p2,
   input  logic [STATE_BITS-1:0] state_p3,
   input  logic [STATE_BITS-1:0] state_out,
   input  logic                  last_site,
   output logic                  push,
   output logic [COUNT_BITS-1:0] push_abba,
   output logic [COUNT_BITS-1:0] push_baba
);

   logic [COUNT_BITS-1:0] abba_ff, abba_in;
   logic [COUNT_BITS-1:0] baba_ff, baba_in;
   logic                  is_abba, is_baba;
   logic [COUNT_BITS-1:0] abba_next, baba_next;

   assign is_abba = (state_p1 == state_out) && (state_p2 == state_p3) && (state_p1 != state_p2);
   assign is_baba = (state_p1 == state_p3) && (state_p2 == state_out) && (state_p1 != state_p2);

   // Saturate at all ones
   assign abba_next = (is_abba && (abba_ff != '1)) ? abba_ff + COUNT_BITS'(1) : abba_ff;
   assign baba_next = (is_baba && (baba_ff != '1)) ? baba_ff + COUNT_BITS'(1) : baba_ff;

   assign push      = site_valid && last_site;
   assign push_abba = abba_next;
   assign push_baba = baba_next;

   always_comb begin
      abba_in = abba_ff;
      baba_in = baba_ff;
      if (site_valid) begin
         if (last_site) begin
            abba_in = '0;
            baba_in = '0;
         end else begin
            abba_in = abba_next;
            baba_in = baba_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abba_ff <= '0;
         baba_ff <= '0;
      end else begin
         abba_ff <= abba_in;
         baba_ff <= baba_in;
      end
   end

endmodule

@@ hw/rtl/abba_fifo.sv @@
`timescale 1ns / 1ps
module abba_fifo #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      rd_data,
   output abba_pkg::q_status_type status
);

   localparam int PTR_BITS = $clog2(abba_pkg::Q_DEPTH);

   logic [WIDTH-1:0]    slot_ff [abba_pkg::Q_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] ptr_advance(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(abba_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PTR_BITS + 1)'(abba_pkg::Q_DEPTH));
   assign rd_data      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/abba_back.sv @@
`timescale 1ns / 1ps
`include "abba_baba_d_statistic_macros.svh"
module abba_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  abba_pkg::q_status_type                 status,
   input  logic [COUNT_BITS-1:0]                  pop_abba,
   input  logic [COUNT_BITS-1:0]                  pop_baba,
   output logic                                   pop,
   output logic                                   rsp_strobe,
   output logic signed [abba_pkg::D_WIDTH-1:0]    rsp_d_value,
   output logic [abba_pkg::OUT_COUNT_BITS-1:0]    rsp_abba_total,
   output logic [abba_pkg::OUT_COUNT_BITS-1:0]    rsp_baba_total,
   output logic                                   rsp_undefined_flag
);

   localparam int OB = abba_pkg::OUT_COUNT_BITS;
   localparam int DW = abba_pkg::D_WIDTH;
   localparam int QS = abba_pkg::Q_STEPS;
   localparam int SB = abba_pkg::STEP_BITS;

   abba_pkg::back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] abba_ff, baba_ff;
   logic [COUNT_BITS:0]   sum_ff, rem_ff, rem_in;
   logic                  neg_ff, undef_ff;
   logic [QS-2:0]         quot_ff;
   logic [SB-1:0]         step_ff;

   logic [COUNT_BITS-1:0] pop_mag;
   logic [COUNT_BITS+1:0] trial;
   logic [COUNT_BITS+1:0] diff;
   logic                  ge;
   logic                  last_step;
   logic [QS-1:0]         q_final;
   logic [DW-1:0]         d_final;
   logic [OB-1:0]         abba_clip, baba_clip;

   logic                  strobe_ff;
   logic [DW-1:0]         d_ff;
   logic [OB-1:0]         abba_out_ff, baba_out_ff;
   logic                  undef_out_ff;

   assign pop     = (state_ff == abba_pkg::ST_IDLE) && !status.empty;
   assign pop_mag = (pop_abba >= pop_baba) ? pop_abba - pop_baba : pop_baba - pop_abba;

   // First step checks the integer bit, later steps shift in one fraction bit each
   assign trial     = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge        = trial >= {1'b0, sum_ff};
   assign diff      = trial - {1'b0, sum_ff};
   assign rem_in    = ge ? diff[COUNT_BITS:0] : trial[COUNT_BITS:0];
   assign last_step = (step_ff == SB'(QS - 1));
   assign q_final   = {quot_ff, ge};
   assign d_final   = undef_ff ? '0
                     : (neg_ff ? DW'(0) - DW'(q_final) : DW'(q_final));

   generate
      if (COUNT_BITS > OB) begin : g_clip
         assign abba_clip = (|abba_ff[COUNT_BITS-1:OB]) ? '1 : abba_ff[OB-1:0];
         assign baba_clip = (|baba_ff[COUNT_BITS-1:OB]) ? '1 : baba_ff[OB-1:0];
      end else if (COUNT_BITS == OB) begin : g_same
         assign abba_clip = abba_ff;
         assign baba_clip = baba_ff;
      end else begin : g_ext
         assign abba_clip = {{(OB - COUNT_BITS){1'b0}}, abba_ff};
         assign baba_clip = {{(OB - COUNT_BITS){1'b0}}, baba_ff};
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abba_pkg::ST_IDLE: begin
            if (!status.empty) begin
               state_in = abba_pkg::ST_DIV;
            end
         end
         abba_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = abba_pkg::ST_IDLE;
            end
         end
         default: state_in = abba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= abba_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == abba_pkg::ST_DIV) && last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         abba_ff  <= pop_abba;
         baba_ff  <= pop_baba;
         sum_ff   <= {1'b0, pop_abba} + {1'b0, pop_baba};
         rem_ff   <= {1'b0, pop_mag};
         neg_ff   <= pop_abba < pop_baba;
         undef_ff <= (pop_abba == '0) && (pop_baba == '0);
         quot_ff  <= '0;
         step_ff  <= '0;
      end else if (state_ff == abba_pkg::ST_DIV) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[QS-3:0], ge};
         step_ff <= step_ff + SB'(1);
      end
      if ((state_ff == abba_pkg::ST_DIV) && last_step) begin
         d_ff         <= d_final;
         abba_out_ff  <= abba_clip;
         baba_out_ff  <= baba_clip;
         undef_out_ff <= undef_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_d_value        = d_ff;
   assign rsp_abba_total     = abba_out_ff;
   assign rsp_baba_total     = baba_out_ff;
   assign rsp_undefined_flag = undef_out_ff;

   `AB_ASSERT_IMPLY(a_strobe_after_div, clock, reset, strobe_ff, $past(state_ff == abba_pkg::ST_DIV))
   `AB_ASSERT_IMPLY(a_rem_bounded, clock, reset, (state_ff == abba_pkg::ST_DIV) && !undef_ff, rem_ff <= sum_ff)
   `AB_ASSERT_IMPLY(a_undef_zero, clock, reset, strobe_ff && undef_out_ff, d_ff == '0)
   `AB_ASSERT_IMPLY(a_d_range, clock, reset, strobe_ff, ($signed(d_ff) <= $signed(DW'(16384))) && ($signed(d_ff) >= -$signed(DW'(16384))))

endmodule

@@ hw/rtl/abba_baba_d_statistic.sv @@
`timescale 1ns / 1ps
// Patterson's D statistic (ABBA-BABA) over a stream of alignment sites.
// Drive one site per cycle with start high while busy is low; a site whose
// req_last_site is set closes the alignment. The front counts ABBA and BABA
// sites at one site per cycle (saturating at 2**COUNT_BITS-1) and, on the last
// site, hands both totals to a two-entry queue and clears its counters, so the
// next alignment streams in at once. The back pops the queue and computes D in
// Q1.14 (truncated toward zero) with a shared restoring divider, one quotient
// bit per cycle: a result appears on the rsp_ ports with rsp_strobe high for
// exactly one cycle, registered after the last quotient step. The receiver
// cannot stall: capture the result in the strobe cycle. busy is high only
// while the queue is full, i.e. when alignments end faster than the divider
// finishes them. With both counts zero, rsp_undefined_flag is set and D is 0;
// totals beyond 32 bits report as all ones.
module abba_baba_d_statistic #(
   parameter int STATE_BITS = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [STATE_BITS-1:0]                req_state_p1,
   input  logic [STATE_BITS-1:0]                req_state_p2,
   input  logic [STATE_BITS-1:0]                req_state_p3,
   input  logic [STATE_BITS-1:0]                req_state_out,
   input  logic                                 req_last_site,
   output logic                                 rsp_strobe,
   output logic signed [abba_pkg::D_WIDTH-1:0]  rsp_d_value,
   output logic [abba_pkg::OUT_COUNT_BITS-1:0]  rsp_abba_total,
   output logic [abba_pkg::OUT_COUNT_BITS-1:0]  rsp_baba_total,
   output logic                                 rsp_undefined_flag
);

   abba_pkg::q_status_type q_status;

   logic                  site_valid;
   logic                  push;
   logic [COUNT_BITS-1:0] push_abba, push_baba;
   logic                  pop;
   logic [2*COUNT_BITS-1:0] rd_data;

   // Hold off new sites only while the queue has no room for a finished alignment
   assign busy       = q_status.full;
   assign site_valid = start && !busy;

   abba_front #(
      .STATE_BITS (STATE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .site_valid (site_valid),
      .state_p1   (req_state_p1),
      .state_p2   (req_state_p2),
      .state_p3   (req_state_p3),
      .state_out  (req_state_out),
      .last_site  (req_last_site),
      .push       (push),
      .push_abba  (push_abba),
      .push_baba  (push_baba)
   );

   // Queue the closed alignment's totals for the divider
   abba_fifo #(
      .WIDTH (2 * COUNT_BITS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data ({push_abba, push_baba}),
      .pop     (pop),
      .rd_data (rd_data),
      .status  (q_status)
   );

   abba_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .status             (q_status),
      .pop_abba           (rd_data[2*COUNT_BITS-1:COUNT_BITS]),
      .pop_baba           (rd_data[COUNT_BITS-1:0]),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_d_value        (rsp_d_value),
      .rsp_abba_total     (rsp_abba_total),
      .rsp_baba_total     (rsp_baba_total),
      .rsp_undefined_flag (rsp_undefined_flag)
   );

endmodule

@@ tb/tb_abba_baba_d_statistic.sv @@
`timescale 1ns / 1ps
module tb_abba_baba_d_statistic;

   localparam int STATE_W   = 8;
   localparam int COUNT_W   = 32;
   localparam int N_RANDOM  = 1700;
   localparam int CALM_TAIL = 300;   // last sites driven with no gaps
   localparam int DRAIN_MAX = 2000;  // cycles allowed for results to arrive at the end
   localparam int SETTLE    = 40;    // divider latency plus queue depth, with margin

   typedef enum int {
      KIND_ABBA,
      KIND_BABA,
      KIND_NEAR,
      KIND_NOISE
   } site_kind_type;

   // One alignment site as the sender presents it
   typedef struct {
      logic [STATE_W-1:0] p1;
      logic [STATE_W-1:0] p2;
      logic [STATE_W-1:0] p3;
      logic [STATE_W-1:0] po;
      logic               last;
      bit                 drain;   // hold this site back until no result is due
   } site_type;

   // One expected D statistic result
   typedef struct {
      logic signed [abba_pkg::D_WIDTH-1:0] d;
      logic [abba_pkg::OUT_COUNT_BITS-1:0] abba;
      logic [abba_pkg::OUT_COUNT_BITS-1:0] baba;
      logic                                undef;
   } d_result_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [STATE_W-1:0]                  req_state_p1;
   logic [STATE_W-1:0]                  req_state_p2;
   logic [STATE_W-1:0]                  req_state_p3;
   logic [STATE_W-1:0]                  req_state_out;
   logic                                req_last_site;
   logic                                rsp_strobe;
   logic signed [abba_pkg::D_WIDTH-1:0] rsp_d_value;
   logic [abba_pkg::OUT_COUNT_BITS-1:0] rsp_abba_total;
   logic [abba_pkg::OUT_COUNT_BITS-1:0] rsp_baba_total;
   logic                                rsp_undefined_flag;

   site_type      site_plan[$];      // sites still to be presented
   d_result_type  stats_due[$];      // D results predicted but not yet seen
   logic [COUNT_W-1:0] tally_abba;
   logic [COUNT_W-1:0] tally_baba;
   logic       site_taken;        // the site on the ports was accepted at the last edge
   int         planned_sites;
   int         sent_sites;
   int         gap_left;
   int         calm_left;
   int         mismatches;

   abba_baba_d_statistic #(
      .STATE_BITS(STATE_W),
      .COUNT_BITS(COUNT_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_state_p1      (req_state_p1),
      .req_state_p2      (req_state_p2),
      .req_state_p3      (req_state_p3),
      .req_state_out     (req_state_out),
      .req_last_site     (req_last_site),
      .rsp_strobe        (rsp_strobe),
      .rsp_d_value       (rsp_d_value),
      .rsp_abba_total    (rsp_abba_total),
      .rsp_baba_total    (rsp_baba_total),
      .rsp_undefined_flag(rsp_undefined_flag)
   );

   // 4 ns clock, low first so no rising edge comes at time zero
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // D in Q1.14 from the two tallies, truncated toward zero; zero when both are empty
   function automatic logic signed [abba_pkg::D_WIDTH-1:0] d_q14_of(
         logic [COUNT_W-1:0] abba, logic [COUNT_W-1:0] baba);
      longint unsigned sum;
      longint unsigned mag;
      longint unsigned q;
      sum = longint'(abba) + longint'(baba);
      if (sum == 0)
         return '0;
      mag = (abba >= baba) ? longint'(abba - baba) : longint'(baba - abba);
      q = (mag * (64'd1 << abba_pkg::D_FRAC_BITS)) / sum;
      if (abba < baba)
         q = 64'd0 - q;
      return q[abba_pkg::D_WIDTH-1:0];
   endfunction

   // Clamp a tally to the width of the result fields
   function automatic logic [abba_pkg::OUT_COUNT_BITS-1:0] clamp_total(
         logic [COUNT_W-1:0] c);
      if (longint'(c) > longint'({abba_pkg::OUT_COUNT_BITS{1'b1}}))
         return '1;
      return c[abba_pkg::OUT_COUNT_BITS-1:0];
   endfunction

   // Count one accepted site and, on the last site, queue the D result and clear
   task automatic tally_site(logic [STATE_W-1:0] p1, logic [STATE_W-1:0] p2,
                             logic [STATE_W-1:0] p3, logic [STATE_W-1:0] po,
                             logic last);
      d_result_type want;
      if (p1 == po && p2 == p3 && p1 != p2 && tally_abba != '1)
         tally_abba = tally_abba + COUNT_W'(1);
      if (p1 == p3 && p2 == po && p1 != p2 && tally_baba != '1)
         tally_baba = tally_baba + COUNT_W'(1);
      if (last) begin
         want.d     = d_q14_of(tally_abba, tally_baba);
         want.abba  = clamp_total(tally_abba);
         want.baba  = clamp_total(tally_baba);
         want.undef = (tally_abba == '0 && tally_baba == '0);
         stats_due.push_back(want);
         tally_abba = '0;
         tally_baba = '0;
      end
   endtask

   task automatic plan_site(logic [STATE_W-1:0] p1, logic [STATE_W-1:0] p2,
                            logic [STATE_W-1:0] p3, logic [STATE_W-1:0] po,
                            logic last, bit drain = 1'b0);
      site_type s;
      s.p1    = p1;
      s.p2    = p2;
      s.p3    = p3;
      s.po    = po;
      s.last  = last;
      s.drain = drain;
      site_plan.push_back(s);
      planned_sites++;
   endtask

   // Build one site of the given kind from random state codes
   task automatic plan_kind(site_kind_type kind, logic last, bit drain);
      logic [STATE_W-1:0] x;
      logic [STATE_W-1:0] y;
      x = STATE_W'($urandom_range(0, 255));
      y = STATE_W'($urandom_range(0, 255));
      case (kind)
         KIND_ABBA: plan_site(x, y, y, x, last, drain);
         KIND_BABA: plan_site(x, y, x, y, last, drain);
         KIND_NEAR: begin
            // one match short of a pattern, or all codes equal
            case ($urandom_range(0, 3))
               0: plan_site(x, x, x, x, last, drain);
               1: plan_site(x, y, y, y, last, drain);
               2: plan_site(x, y, x, x, last, drain);
               default: plan_site(x, y, y, STATE_W'($urandom_range(0, 255)), last, drain);
            endcase
         end
         default: plan_site(STATE_W'($urandom_range(0, 255)), STATE_W'($urandom_range(0, 255)),
                            STATE_W'($urandom_range(0, 255)), STATE_W'($urandom_range(0, 255)),
                            last, drain);
      endcase
   endtask

   // One alignment: pattern sites biased toward ABBA by abba_pct, plus noise and near misses
   task automatic plan_alignment(int len, int abba_pct, int pattern_pct, bit drain);
      site_kind_type kind;
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < pattern_pct)
            kind = ($urandom_range(0, 99) < abba_pct) ? KIND_ABBA : KIND_BABA;
         else if (r < pattern_pct + (100 - pattern_pct) / 2)
            kind = KIND_NOISE;
         else
            kind = KIND_NEAR;
         plan_kind(kind, (i == len - 1), drain && (i == 0));
      end
   endtask

   // Driver: change inputs on the falling edge, one site at a time from site_plan
   always @(negedge clock) begin
      site_type nxt;
      bit    holding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // hold the current site while it waits out busy
         holding = start && !site_taken;
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (site_plan.size() == 0 ||
                         (site_plan[0].drain && stats_due.size() != 0)) begin
               // nothing left, or let every pending result drain first
               start <= 1'b0;
            end else begin
               if (calm_left > 0)
                  calm_left--;
               else if ($urandom_range(0, 99) < 4)
                  calm_left = $urandom_range(20, 80);
               if (site_plan.size() > CALM_TAIL && calm_left == 0 &&
                   $urandom_range(0, 99) < 15) begin
                  // open an idle burst, counted down in gap_left, this one included
                  gap_left = $urandom_range(1, 10) - 1;
                  start <= 1'b0;
               end else begin
                  nxt = site_plan.pop_front();
                  req_state_p1  <= nxt.p1;
                  req_state_p2  <= nxt.p2;
                  req_state_p3  <= nxt.p3;
                  req_state_out <= nxt.po;
                  req_last_site <= nxt.last;
                  start         <= 1'b1;
               end
            end
         end
      end
   end

   // Monitor: sample on the rising edge; check results before counting a new site
   always @(posedge clock) begin
      d_result_type want;
      if (reset) begin
         site_taken <= 1'b0;
         tally_abba = '0;
         tally_baba = '0;
      end else begin
         site_taken <= start && !busy;
         if (rsp_strobe !== 1'b0) begin
            if (stats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: d=%0d abba=%0d baba=%0d undef=%b",
                           rsp_d_value, rsp_abba_total, rsp_baba_total,
                           rsp_undefined_flag);
            end else begin
               want = stats_due.pop_front();
               if (rsp_strobe !== 1'b1 || rsp_d_value !== want.d ||
                   rsp_abba_total !== want.abba || rsp_baba_total !== want.baba ||
                   rsp_undefined_flag !== want.undef) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected d=%0d abba=%0d baba=%0d undef=%b, got d=%0d abba=%0d baba=%0d undef=%b",
                              want.d, want.abba, want.baba, want.undef,
                              rsp_d_value, rsp_abba_total, rsp_baba_total,
                              rsp_undefined_flag);
               end
            end
         end
         if (start && !busy) begin
            sent_sites++;
            tally_site(req_state_p1, req_state_p2, req_state_p3, req_state_out,
                       req_last_site);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int wait_cycles;
      int len;
      int abba_pct;
      int pattern_pct;
      int first;
      reset         = 1'b1;
      start         = 1'b0;
      req_state_p1  = '0;
      req_state_p2  = '0;
      req_state_p3  = '0;
      req_state_out = '0;
      req_last_site = 1'b0;
      planned_sites = 0;
      sent_sites    = 0;
      gap_left      = 0;
      calm_left     = 0;
      mismatches    = 0;

      // Directed: lone empty alignments, lone full ABBA and full BABA at the code extremes
      plan_site(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      plan_site(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1);
      plan_site(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
      plan_site(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      // mixed counts give negative and positive thirds
      plan_site(8'h01, 8'h02, 8'h02, 8'h01, 1'b0);
      plan_site(8'h03, 8'h04, 8'h03, 8'h04, 1'b0);
      plan_site(8'h05, 8'h06, 8'h05, 8'h06, 1'b1);
      plan_site(8'h10, 8'h20, 8'h20, 8'h10, 1'b0);
      plan_site(8'h30, 8'h40, 8'h40, 8'h30, 1'b0);
      plan_site(8'h50, 8'h60, 8'h50, 8'h60, 1'b1);
      // sites one match short of a pattern, closed by a plain site: still undefined
      plan_site(8'h01, 8'h02, 8'h02, 8'h02, 1'b0);
      plan_site(8'h03, 8'h03, 8'h04, 8'h03, 1'b0);
      plan_site(8'h05, 8'h06, 8'h07, 8'h05, 1'b0);
      plan_site(8'h09, 8'h08, 8'h07, 8'h06, 1'b1);
      // three ABBA, one BABA, closed by a site that counts nothing
      plan_site(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
      plan_site(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
      plan_site(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
      plan_site(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
      plan_site(8'h09, 8'h08, 8'h07, 8'h06, 1'b1);
      // back-to-back last sites fill the result queue and raise busy
      plan_site(8'h7F, 8'h80, 8'h80, 8'h7F, 1'b1);
      plan_site(8'h80, 8'h7F, 8'h80, 8'h7F, 1'b1);
      plan_site(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
      plan_site(8'hC3, 8'h3C, 8'h3C, 8'hC3, 1'b1);

      // Random alignments; the first one waits for every earlier result
      first = 1;
      while (planned_sites < N_RANDOM + 23) begin
         case ($urandom_range(0, 9))
            0, 1:    len = $urandom_range(1, 3);
            2:       len = $urandom_range(60, 150);
            default: len = $urandom_range(1, 30);
         endcase
         case ($urandom_range(0, 9))
            0:       abba_pct = 0;
            1:       abba_pct = 100;
            default: abba_pct = $urandom_range(0, 100);
         endcase
         pattern_pct = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(20, 80);
         plan_alignment(len, abba_pct, pattern_pct,
                        first == 1 || $urandom_range(0, 24) == 0);
         first = 0;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait until every site is in, then for the results, then for any stragglers
      while (sent_sites < planned_sites)
         @(posedge clock);
      wait_cycles = 0;
      while (stats_due.size() != 0 && wait_cycles < DRAIN_MAX) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE) @(posedge clock);
      if (stats_due.size() != 0)
         mismatches += stats_due.size();

      if (mismatches == 0) begin
         $display("tb_abba_baba_d_statistic passed");
      end else begin
         $display("tb_abba_baba_d_statistic failed");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #2000000;
      $display("tb_abba_baba_d_statistic failed");
      $finish;
   end

endmodule
